FILE: rtl/core/nrm_pkg.sv
package nrm_pkg;

    localparam int ELEM_W = 24;
    localparam int NORM_W = 31;
    localparam int SQ_W   = 2 * ELEM_W;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SQ,
        S_ACC,
        S_RGO,
        S_ROOT,
        S_RD,
        S_CALC,
        S_DIV,
        S_PUT
    } nrm_state_t;

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_PASS,
        MODE_SCALE
    } nrm_mode_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_MUL,
        DV_INIT,
        DV_ITER
    } nrm_div_phase_t;

endpackage

FILE: rtl/core/vector_norm_limiter.sv
// Channel   Dir  Handshake                 Payload (low bit up)
// s_*       in   s_tvalid / s_tready       s_tdata: element_in[23:0]; s_tlast: last_in
// m_*       out  m_tvalid / m_tready       m_tdata: element_out[23:0]; m_tlast: last_out
// cfg_*     in   cfg_wr_en (no wait)       cfg_wr_data: norm_limit[30:0]
//
// Loading steps through store write, square multiply and accumulate per word.
// At vector end the norm comes from a bit-serial square root.
// Each result is then read through the store read port, and passes through
// the shift-subtract divider when the vector is scaled.
// Reset clears control, the sum and norm_limit; the element store is not cleared.
// The output register holds a result under m_tready low; the next vector
// may load while the last result of the previous one still waits.
module vector_norm_limiter
    import nrm_pkg::*;
#(
    parameter int MAX_ELEMENTS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,      // element_in[23:0]
    input  logic              s_tlast,      // last_in
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,      // element_out[23:0]
    output logic              m_tlast,      // last_out
    input  logic              cfg_wr_en,
    input  logic [NORM_W-1:0] cfg_wr_data   // norm_limit[30:0]
);

    localparam int IDX_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    // largest sum is MAX_ELEMENTS * 2^46
    localparam int SUM_W  = SQ_W - 1 + $clog2(MAX_ELEMENTS) + 1;
    localparam int ROOT_W = (SUM_W + 1) / 2;

    nrm_state_t          state_reg, state_next;
    nrm_mode_t           mode_reg, mode_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [ELEM_W-1:0]   mag_reg, mag_next;
    logic                end_reg, end_next;
    logic [SQ_W-1:0]     sq_reg, sq_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [ROOT_W-1:0]   norm_reg, norm_next;
    logic [ELEM_W-1:0]   res_reg, res_next;
    logic [NORM_W-1:0]   norm_limit_reg;
    logic                out_valid_reg;
    logic [ELEM_W-1:0]   out_data_reg;
    logic                out_last_reg;

    logic                in_accept;
    logic                out_load;
    logic                is_last;
    logic                mem_re;
    logic [ELEM_W-1:0]   rd_data;
    logic                sqrt_start, sqrt_done;
    logic [ROOT_W-1:0]   sqrt_root;
    logic                div_start, div_done;
    logic [ELEM_W-1:0]   div_quot;

    assign s_tready  = (state_reg == S_LOAD);
    assign in_accept = s_tvalid && s_tready;
    assign is_last   = ((CNT_W'(idx_reg) + 1'b1) == count_reg);

    nrm_store #(
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .clk   (clk),
        .we    (in_accept),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (s_tdata),
        .re    (mem_re),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    nrm_sqrt #(
        .ROOT_W (ROOT_W)
    ) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .operand ((2*ROOT_W)'(sum_reg)),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    nrm_div #(
        .ROOT_W (ROOT_W)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .elem       (rd_data),
        .norm_limit (norm_limit_reg),
        .norm       (norm_reg),
        .done       (div_done),
        .quot       (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        mag_next   = mag_reg;
        end_next   = end_reg;
        sq_next    = sq_reg;
        sum_next   = sum_reg;
        norm_next  = norm_reg;
        res_next   = res_reg;
        mem_re     = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_accept)
                begin
                    mag_next   = s_tdata[ELEM_W-1] ? (~s_tdata + 1'b1) : s_tdata;
                    // vector ends on a last mark or when the store is full
                    end_next   = s_tlast || (count_reg == CNT_W'(MAX_ELEMENTS - 1));
                    count_next = count_reg + 1'b1;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                sq_next    = SQ_W'(mag_reg) * SQ_W'(mag_reg);
                state_next = S_ACC;
            end
            S_ACC:
            begin
                sum_next   = sum_reg + SUM_W'(sq_reg);
                state_next = end_reg ? S_RGO : S_LOAD;
            end
            S_RGO:
            begin
                sqrt_start = 1'b1;
                sum_next   = '0;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (sqrt_done)
                begin
                    norm_next = sqrt_root;
                    if (norm_limit_reg == '0)
                    begin
                        mode_next = MODE_ZERO;
                    end
                    else if (32'(sqrt_root) <= 32'(norm_limit_reg))
                    begin
                        mode_next = MODE_PASS;
                    end
                    else
                    begin
                        mode_next = MODE_SCALE;
                    end
                    idx_next   = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                unique case (mode_reg)
                    MODE_ZERO:
                    begin
                        res_next   = '0;
                        state_next = S_PUT;
                    end
                    MODE_PASS:
                    begin
                        res_next   = rd_data;
                        state_next = S_PUT;
                    end
                    default:
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_next   = div_quot;
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load = 1'b1;
                    if (is_last)
                    begin
                        count_next = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            count_reg      <= '0;
            sum_reg        <= '0;
            norm_limit_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            if (cfg_wr_en)
            begin
                norm_limit_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        idx_reg  <= idx_next;
        mag_reg  <= mag_next;
        end_reg  <= end_next;
        sq_reg   <= sq_next;
        norm_reg <= norm_next;
        res_reg  <= res_next;
        if (out_load)
        begin
            out_data_reg <= res_reg;
            out_last_reg <= is_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ELEMENTS))
        else $error("element count beyond store depth");
    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before taken");
    a_last_returns : assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && is_last) |=> (state_reg == S_LOAD && count_reg == '0))
        else $error("vector end did not return to load");
    a_idx_in_vector : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RD |-> CNT_W'(idx_reg) < count_reg)
        else $error("read past loaded elements");
`endif

endmodule

FILE: rtl/core/nrm_store.sv
module nrm_store
    import nrm_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [ELEM_W-1:0]                       wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [ELEM_W-1:0]                       rdata
);

    logic [ELEM_W-1:0] mem [DEPTH];
    logic [ELEM_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/nrm_sqrt.sv
module nrm_sqrt
    import nrm_pkg::*;
#(
    parameter int ROOT_W = 27
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [2*ROOT_W-1:0]   operand,
    output logic                  done,
    output logic [ROOT_W-1:0]     root
);

    localparam int CW = $clog2(ROOT_W + 1);

    logic [2*ROOT_W-1:0] x_reg;
    logic [ROOT_W+1:0]   rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [CW-1:0]       cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [ROOT_W+1:0]   rem_sh;
    logic [ROOT_W+1:0]   trial;
    logic                fits;

    // one root bit per cycle, restoring
    assign rem_sh = {rem_reg[ROOT_W-1:0], x_reg[2*ROOT_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= operand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= {x_reg[2*ROOT_W-3:0], 2'b00};
            rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

`ifndef SYNTHESIS
    a_no_restart : assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("root restarted while busy");
    a_done_after_busy : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy_reg))
        else $error("root done without work");
    a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(ROOT_W))
        else $error("root counter out of range");
`endif

endmodule

FILE: rtl/core/nrm_div.sv
module nrm_div
    import nrm_pkg::*;
#(
    parameter int ROOT_W = 27
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [ELEM_W-1:0]        elem,
    input  logic [NORM_W-1:0]        norm_limit,
    input  logic [ROOT_W-1:0]        norm,
    output logic                     done,
    output logic [ELEM_W-1:0]        quot
);

    localparam int PW = ELEM_W + NORM_W;
    localparam int CW = $clog2(ELEM_W + 1);

    nrm_div_phase_t    phase_reg;
    logic [CW-1:0]     cnt_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [ELEM_W-1:0] mag_reg;
    logic [PW-1:0]     prod_reg;
    logic [ROOT_W:0]   rem_reg;
    logic [ELEM_W-1:0] low_reg;

    logic [ROOT_W:0]   rem_sh;
    logic              fits;

    // quotient < |elem| since norm > norm_limit, so ELEM_W quotient bits suffice
    assign rem_sh = {rem_reg[ROOT_W-1:0], low_reg[ELEM_W-1]};
    assign fits   = (rem_sh >= {1'b0, norm});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= DV_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                DV_IDLE:
                begin
                    if (start)
                    begin
                        phase_reg <= DV_MUL;
                    end
                end
                DV_MUL:
                begin
                    phase_reg <= DV_INIT;
                end
                DV_INIT:
                begin
                    phase_reg <= DV_ITER;
                    cnt_reg   <= CW'(ELEM_W);
                end
                DV_ITER:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1))
                    begin
                        phase_reg <= DV_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    phase_reg <= DV_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= elem[ELEM_W-1];
            mag_reg <= elem[ELEM_W-1] ? (~elem + 1'b1) : elem;
        end
        if (phase_reg == DV_MUL)
        begin
            prod_reg <= PW'(mag_reg) * PW'(norm_limit);
        end
        if (phase_reg == DV_INIT)
        begin
            rem_reg <= {1'b0, prod_reg[ELEM_W +: ROOT_W]};
            low_reg <= prod_reg[ELEM_W-1:0];
        end
        else if (phase_reg == DV_ITER)
        begin
            rem_reg <= fits ? (rem_sh - {1'b0, norm}) : rem_sh;
            low_reg <= {low_reg[ELEM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? (~low_reg + 1'b1) : low_reg;

`ifndef SYNTHESIS
    a_start_idle : assert property (@(posedge clk) disable iff (!rst_n)
        start |-> phase_reg == DV_IDLE)
        else $error("divide started while busy");
    a_done_from_iter : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(phase_reg) == DV_ITER)
        else $error("divide done out of sequence");
    a_rem_below_norm : assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == DV_ITER && cnt_reg != CW'(ELEM_W) |-> rem_reg < {1'b0, norm})
        else $error("divide remainder not reduced");
`endif

endmodule
